>>> rtl/core/vtla_pkg.sv
// Package for the vertex transform and line assembler.
// Holds the beat payload types, primitive modes and register indexes.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package vtla_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    PRIM_POINTS = 2'd0,
    PRIM_LINES  = 2'd1,
    PRIM_LOOP   = 2'd2,
    PRIM_STRIP  = 2'd3
  } prim_mode_t;

  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_C    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_D    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_X   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_Y   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_PRIM_MODE = 3'd6;

  localparam logic signed [COORD_W-1:0] COEF_UNITY = 32'sd65536;
  localparam logic signed [COORD_W-1:0] COEF_ZERO  = 32'sd0;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      contour_end;
    logic                      shape_end;
  } vertex_t;

  typedef struct packed {
    logic [INDEX_W-1:0] vertex_number;
    logic               edge_valid;
    logic [INDEX_W-1:0] edge_from;
    logic [INDEX_W-1:0] edge_to;
    logic               close_valid;
    logic [INDEX_W-1:0] close_from;
    logic [INDEX_W-1:0] close_to;
  } index_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic [INDEX_W-1:0]        vertex_number;
    logic                      edge_valid;
    logic [INDEX_W-1:0]        edge_from;
    logic [INDEX_W-1:0]        edge_to;
    logic                      close_valid;
    logic [INDEX_W-1:0]        close_from;
    logic [INDEX_W-1:0]        close_to;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/vtla_channels.sv
// Valid/ready channel interfaces for vertex beats and result beats.
// Depends on vtla_pkg for the payload types.
`default_nettype none

interface vtla_vertex_if;
  logic             valid;
  logic             ready;
  vtla_pkg::vertex_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vtla_result_if;
  logic             valid;
  logic             ready;
  vtla_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/vertex_transform_line_assembler.sv
// Top level: affine vertex transform with line primitive index assembly.
// Depends on vtla_pkg and the channel interfaces in vtla_channels.sv.
//
//   channel   | dir | beat contents
//   ----------+-----+-------------------------------------------------
//   vtx       | in  | px, py, contour_end, shape_end
//   res       | out | qx, qy, vertex_number, edge and closing pairs
//   cfg_*     | in  | write enable, register index, write data
//
// One beat is taken every cycle while vtx.ready is high; a result is offered once
// its vertex beat has passed the input register, product register, sum register
// and result register of the transform pipeline, in that order.
// Reset restores the transform and mode registers, clears the counters and
// empties the pipeline. A stall on res holds the result register, earlier
// stages move up only into empty slots, and vtx.ready falls only once the
// pipeline is full.
`default_nettype none

module vertex_transform_line_assembler #(
  parameter int unsigned MAX_VERTICES = 65536
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  vtla_vertex_if.sink                             vtx,
  vtla_result_if.source                           res,
  input  wire logic                               cfg_we,
  input  wire logic [vtla_pkg::CFG_ADDR_W-1:0]    cfg_index,
  input  wire logic [vtla_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned NUM_MOD = (MAX_VERTICES < 65536) ? MAX_VERTICES : 65536;
  localparam logic [vtla_pkg::INDEX_W-1:0] NUM_TOP = vtla_pkg::INDEX_W'(NUM_MOD - 1);
  localparam logic [vtla_pkg::INDEX_W-1:0] POS_TOP = '1;
  localparam logic [vtla_pkg::INDEX_W-1:0] POS_RESTART = 16'd2;

  logic signed [31:0]   coef_a, coef_b, coef_c, coef_d, shift_x, shift_y;
  vtla_pkg::prim_mode_t prim_mode;

  logic [vtla_pkg::INDEX_W-1:0] next_number, contour_base, position_in_contour;

  // Pipeline stage valids and payloads.
  logic                 v1, v2, v3;
  logic signed [31:0]   x1, y1;
  vtla_pkg::index_t     idx1, idx2, idx3;
  logic signed [63:0]   p_ax, p_by, p_cx, p_dy;
  logic signed [48:0]   lin_x, lin_y;

  logic en_out, en3, en2, en1, accept;

  assign en_out    = !res.valid || res.ready;
  assign en3       = !v3 || en_out;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign vtx.ready = en1;
  assign accept    = vtx.valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a    <= vtla_pkg::COEF_UNITY;
      coef_b    <= vtla_pkg::COEF_ZERO;
      coef_c    <= vtla_pkg::COEF_ZERO;
      coef_d    <= vtla_pkg::COEF_UNITY;
      shift_x   <= vtla_pkg::COEF_ZERO;
      shift_y   <= vtla_pkg::COEF_ZERO;
      prim_mode <= vtla_pkg::PRIM_POINTS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vtla_pkg::REG_COEF_A:    coef_a    <= cfg_data;
        vtla_pkg::REG_COEF_B:    coef_b    <= cfg_data;
        vtla_pkg::REG_COEF_C:    coef_c    <= cfg_data;
        vtla_pkg::REG_COEF_D:    coef_d    <= cfg_data;
        vtla_pkg::REG_SHIFT_X:   shift_x   <= cfg_data;
        vtla_pkg::REG_SHIFT_Y:   shift_y   <= cfg_data;
        vtla_pkg::REG_PRIM_MODE: prim_mode <= vtla_pkg::prim_mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // Index assembly for the vertex being taken in this cycle.
  logic                         contour_last;
  logic [vtla_pkg::INDEX_W-1:0] num_inc, num_prev;
  vtla_pkg::index_t             idx_new;

  always_comb begin
    contour_last = vtx.data.contour_end || vtx.data.shape_end;
    num_inc  = (next_number == NUM_TOP) ? '0 : next_number + 16'd1;
    num_prev = (next_number == '0) ? NUM_TOP : next_number - 16'd1;
    idx_new  = '0;
    idx_new.vertex_number = next_number;
    unique case (prim_mode)
      vtla_pkg::PRIM_POINTS: ;
      vtla_pkg::PRIM_LINES:  idx_new.edge_valid = position_in_contour[0];
      vtla_pkg::PRIM_LOOP: begin
        idx_new.edge_valid  = position_in_contour != '0;
        idx_new.close_valid = contour_last;
      end
      vtla_pkg::PRIM_STRIP:  idx_new.edge_valid = position_in_contour != '0;
      default: ;
    endcase
    if (idx_new.edge_valid) begin
      idx_new.edge_from = num_prev;
      idx_new.edge_to   = next_number;
    end
    if (idx_new.close_valid) begin
      idx_new.close_from = next_number;
      idx_new.close_to   = contour_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_number         <= '0;
      contour_base        <= '0;
      position_in_contour <= '0;
    end else if (accept) begin
      if (vtx.data.shape_end) begin
        next_number         <= '0;
        contour_base        <= '0;
        position_in_contour <= '0;
      end else if (contour_last) begin
        next_number         <= num_inc;
        contour_base        <= num_inc;
        position_in_contour <= '0;
      end else begin
        next_number         <= num_inc;
        position_in_contour <= (position_in_contour == POS_TOP) ?
                               POS_RESTART : position_in_contour + 16'd1;
      end
    end
  end

  // Sums of products: the exact sum shifted right by 16 is the floor step.
  logic signed [64:0] sum_x, sum_y;
  assign sum_x = $signed({p_ax[63], p_ax}) + $signed({p_by[63], p_by});
  assign sum_y = $signed({p_cx[63], p_cx}) + $signed({p_dy[63], p_dy});

  // Translation and saturation to 32 bits.
  logic signed [49:0] tot_x, tot_y;
  logic signed [31:0] sat_x, sat_y;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic fits;
    fits = (v[49:31] == '0) || (v[49:31] == '1);
    if (fits) begin
      return v[31:0];
    end else if (v[49]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

  always_comb begin
    tot_x = $signed({lin_x[48], lin_x}) + $signed({{18{shift_x[31]}}, shift_x});
    tot_y = $signed({lin_y[48], lin_y}) + $signed({{18{shift_y[31]}}, shift_y});
    sat_x = sat32(tot_x);
    sat_y = sat32(tot_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (en1)    v1        <= vtx.valid;
      if (en2)    v2        <= v1;
      if (en3)    v3        <= v2;
      if (en_out) res.valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1   <= vtx.data.px;
      y1   <= vtx.data.py;
      idx1 <= idx_new;
    end
    if (en2 && v1) begin
      p_ax <= coef_a * x1;
      p_by <= coef_b * y1;
      p_cx <= coef_c * x1;
      p_dy <= coef_d * y1;
      idx2 <= idx1;
    end
    if (en3 && v2) begin
      lin_x <= sum_x[64:16];
      lin_y <= sum_y[64:16];
      idx3  <= idx2;
    end
    if (en_out && v3) begin
      res.data.qx            <= sat_x;
      res.data.qy            <= sat_y;
      res.data.vertex_number <= idx3.vertex_number;
      res.data.edge_valid    <= idx3.edge_valid;
      res.data.edge_from     <= idx3.edge_from;
      res.data.edge_to       <= idx3.edge_to;
      res.data.close_valid   <= idx3.close_valid;
      res.data.close_from    <= idx3.close_from;
      res.data.close_to      <= idx3.close_to;
    end
  end

endmodule

`default_nettype wire

>>> test/vertex_transform_line_assembler_tb.sv
// Testbench for vertex_transform_line_assembler: affine transform and line index assembly.
// Drives vertex beats and register writes, predicts every result beat and checks each field.
// Depends on vtla_pkg and the channel interfaces in vtla_channels.sv.
`default_nettype none

module vertex_transform_line_assembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [vtla_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
  localparam int PIPE_LATENCY = 4;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_CONTOUR = 40;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int PHASE_ITEMS = 100;
  localparam logic signed [79:0] Q_MAX = 80'sd2147483647;
  localparam logic signed [79:0] Q_MIN = -80'sd2147483648;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [vtla_pkg::CFG_ADDR_W-1:0] cfg_index;
  logic [vtla_pkg::CFG_DATA_W-1:0] cfg_data;

  vtla_vertex_if vtx_ch ();
  vtla_result_if res_ch ();

  vertex_transform_line_assembler dut (
    .clk       (clk),
    .rst       (rst),
    .vtx       (vtx_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted transform registers and assembly counters.
  logic signed [31:0] m_xx = vtla_pkg::COEF_UNITY;
  logic signed [31:0] m_xy = vtla_pkg::COEF_ZERO;
  logic signed [31:0] m_yx = vtla_pkg::COEF_ZERO;
  logic signed [31:0] m_yy = vtla_pkg::COEF_UNITY;
  logic signed [31:0] m_tx = vtla_pkg::COEF_ZERO;
  logic signed [31:0] m_ty = vtla_pkg::COEF_ZERO;
  vtla_pkg::prim_mode_t active_mode = vtla_pkg::PRIM_POINTS;
  logic [15:0] next_index = '0;
  logic [15:0] first_index = '0;
  logic [15:0] contour_slot = '0;

  vtla_pkg::result_t transformed_vertices[$];

  int mismatch_count = 0;
  int results_seen = 0;
  int vertices_sent = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit sender_steady = 1'b0;

  logic sink_ready = 1'b0;
  logic sink_on = 1'b1;
  int sink_left = 0;
  logic sink_steady = 1'b0;
  logic holding = 1'b0;
  event holdoff_start;

  assign res_ch.ready = sink_ready;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("vertex_transform_line_assembler verification failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] map_axis(input logic signed [31:0] k0, k1, offset,
                                                  input logic signed [31:0] u, w);
    logic signed [79:0] e0, e1, eu, ew, et, acc;
    e0 = k0;
    e1 = k1;
    eu = u;
    ew = w;
    et = offset;
    acc = ((e0 * eu + e1 * ew) >>> 16) + et;
    if (acc > Q_MAX) acc = Q_MAX;
    if (acc < Q_MIN) acc = Q_MIN;
    return acc[31:0];
  endfunction

  function automatic vtla_pkg::result_t transform_vertex(input vtla_pkg::vertex_t v);
    vtla_pkg::result_t r;
    logic contour_last;
    logic [15:0] num;
    r = '0;
    contour_last = v.contour_end | v.shape_end;
    num = next_index;
    r.qx = map_axis(m_xx, m_xy, m_tx, v.px, v.py);
    r.qy = map_axis(m_yx, m_yy, m_ty, v.px, v.py);
    r.vertex_number = num;
    case (active_mode)
      vtla_pkg::PRIM_LINES: r.edge_valid = contour_slot[0];
      vtla_pkg::PRIM_LOOP: begin
        r.edge_valid = (contour_slot != 0);
        r.close_valid = contour_last;
      end
      vtla_pkg::PRIM_STRIP: r.edge_valid = (contour_slot != 0);
      default: ;
    endcase
    if (r.edge_valid) begin
      r.edge_from = num - 16'd1;
      r.edge_to = num;
    end
    if (r.close_valid) begin
      r.close_from = num;
      r.close_to = first_index;
    end
    next_index = num + 16'd1;
    if (contour_last) begin
      first_index = next_index;
      contour_slot = '0;
    end else begin
      contour_slot = (contour_slot == 16'hFFFF) ? 16'd2 : contour_slot + 16'd1;
    end
    if (v.shape_end) begin
      next_index = '0;
      first_index = '0;
      contour_slot = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s: got %h, expected %h", results_seen, name,
                                got, want));
  endtask

  task automatic check_result(input vtla_pkg::result_t got);
    vtla_pkg::result_t want;
    if (transformed_vertices.size() == 0) begin
      report_mismatch($sformatf("beat %0d arrived with no vertex outstanding", results_seen));
      return;
    end
    want = transformed_vertices.pop_front();
    check_field("qx", got.qx, want.qx);
    check_field("qy", got.qy, want.qy);
    check_field("vertex_number", 32'(got.vertex_number), 32'(want.vertex_number));
    check_field("edge_valid", 32'(got.edge_valid), 32'(want.edge_valid));
    check_field("edge_from", 32'(got.edge_from), 32'(want.edge_from));
    check_field("edge_to", 32'(got.edge_to), 32'(want.edge_to));
    check_field("close_valid", 32'(got.close_valid), 32'(want.close_valid));
    check_field("close_from", 32'(got.close_from), 32'(want.close_from));
    check_field("close_to", 32'(got.close_to), 32'(want.close_to));
  endtask

  // The sink alternates runs of ready with short stalls; now and then a long run.
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
    end else begin
      if (res_ch.valid && sink_ready) begin
        check_result(res_ch.data);
        results_seen++;
      end
      if (sink_left != 0) begin
        sink_left <= sink_left - 1;
      end else begin
        sink_on <= !sink_on;
        if (sink_on) sink_left <= $urandom_range(0, 4);
        else if ($urandom_range(0, 7) == 0) sink_left <= $urandom_range(40, 80);
        else sink_left <= $urandom_range(0, 12);
      end
      sink_ready <= !holding && (sink_steady || sink_on);
    end
  end

  initial begin
    forever begin
      @(holdoff_start);
      holding <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5: return {{14{w[17]}}, w[17:0]};
      default: return w;
    endcase
  endfunction

  function automatic logic [31:0] pick_coef();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: return vtla_pkg::COEF_UNITY;
      1: return -vtla_pkg::COEF_UNITY;
      2: return vtla_pkg::COEF_ZERO;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      5, 6, 7: return {{13{w[18]}}, w[18:0]};
      default: return w;
    endcase
  endfunction

  task automatic send_vertex(input logic signed [31:0] x, y, input logic ce, se);
    vtla_pkg::vertex_t v;
    vtla_pkg::result_t predicted;
    int gap;
    v.px = x;
    v.py = y;
    v.contour_end = ce;
    v.shape_end = se;
    vtx_ch.valid <= 1'b1;
    vtx_ch.data <= v;
    @(posedge clk);
    while (!vtx_ch.ready) @(posedge clk);
    predicted = transform_vertex(v);
    transformed_vertices.insert(transformed_vertices.size(), predicted);
    vertices_sent++;
    if (!sender_steady) begin
      if (burst_left != 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(1, 6);
        vtx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 8);
      end
    end
  endtask

  task automatic wait_drained();
    vtx_ch.valid <= 1'b0;
    while (transformed_vertices.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [vtla_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      vtla_pkg::REG_COEF_A: m_xx = value;
      vtla_pkg::REG_COEF_B: m_xy = value;
      vtla_pkg::REG_COEF_C: m_yx = value;
      vtla_pkg::REG_COEF_D: m_yy = value;
      vtla_pkg::REG_SHIFT_X: m_tx = value;
      vtla_pkg::REG_SHIFT_Y: m_ty = value;
      vtla_pkg::REG_PRIM_MODE: active_mode = vtla_pkg::prim_mode_t'(value[1:0]);
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
    send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1);
  endtask

  task automatic test_saturation();
    wait_drained();
    write_reg(vtla_pkg::REG_COEF_A, 32'h7FFF_FFFF);
    write_reg(vtla_pkg::REG_COEF_B, 32'h7FFF_FFFF);
    write_reg(vtla_pkg::REG_COEF_C, 32'h8000_0000);
    write_reg(vtla_pkg::REG_COEF_D, 32'h8000_0000);
    write_reg(vtla_pkg::REG_SHIFT_X, 32'h7FFF_FFFF);
    write_reg(vtla_pkg::REG_SHIFT_Y, 32'h8000_0000);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send_vertex(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1);
  endtask

  task automatic test_prim_modes();
    vtla_pkg::prim_mode_t m;
    wait_drained();
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    for (int i = 0; i < 4; i++) begin
      m = vtla_pkg::prim_mode_t'(i);
      wait_drained();
      // In lines mode the upper data bits are set to show they are ignored.
      if (m == vtla_pkg::PRIM_LINES) write_reg(vtla_pkg::REG_PRIM_MODE, {30'h3FFF_FFFF, m});
      else write_reg(vtla_pkg::REG_PRIM_MODE, 32'(m));
      send_vertex(pick_word(), pick_word(), 1'b0, 1'b0);
      send_vertex(pick_word(), pick_word(), 1'b0, 1'b0);
      send_vertex(pick_word(), pick_word(), 1'b1, 1'b0);
      if (m == vtla_pkg::PRIM_LOOP) send_vertex(pick_word(), pick_word(), 1'b1, 1'b0);
      send_vertex(pick_word(), pick_word(), 1'b0, 1'b0);
      send_vertex(pick_word(), pick_word(), 1'b0, 1'b1);
    end
  endtask

  // A short contour shifts the numbering, then a long contour in lines mode runs
  // back to back with the sink always ready.
  task automatic test_long_contour();
    wait_drained();
    write_reg(vtla_pkg::REG_PRIM_MODE, 32'(vtla_pkg::PRIM_LINES));
    sender_steady = 1'b1;
    sink_steady <= 1'b1;
    send_vertex(pick_word(), pick_word(), 1'b0, 1'b0);
    send_vertex(pick_word(), pick_word(), 1'b0, 1'b0);
    send_vertex(pick_word(), pick_word(), 1'b1, 1'b0);
    for (int i = 0; i < LONG_CONTOUR; i++)
      send_vertex(pick_word(), pick_word(), 1'b0, i == LONG_CONTOUR - 1);
    sender_steady = 1'b0;
    sink_steady <= 1'b0;
  endtask

  task automatic test_backpressure();
    wait_drained();
    write_reg(vtla_pkg::REG_PRIM_MODE, 32'(vtla_pkg::PRIM_LOOP));
    sender_steady = 1'b1;
    -> holdoff_start;
    repeat (40) send_vertex(pick_word(), pick_word(), $urandom_range(0, 3) == 0, 1'b0);
    sender_steady = 1'b0;
    wait_drained();
    repeat (19) send_vertex(pick_word(), pick_word(), $urandom_range(0, 3) == 0, 1'b0);
    send_vertex(pick_word(), pick_word(), 1'b0, 1'b1);
  endtask

  task automatic send_random_shape();
    int contours;
    int len;
    contours = $urandom_range(1, 4);
    for (int c = 0; c < contours; c++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++)
        send_vertex(pick_word(), pick_word(), k == len - 1,
                    (c == contours - 1) && (k == len - 1));
    end
  endtask

  task automatic test_random_traffic();
    int phase_end;
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      write_reg(vtla_pkg::REG_COEF_A, pick_coef());
      write_reg(vtla_pkg::REG_COEF_B, pick_coef());
      write_reg(vtla_pkg::REG_COEF_C, pick_coef());
      write_reg(vtla_pkg::REG_COEF_D, pick_coef());
      write_reg(vtla_pkg::REG_SHIFT_X, pick_word());
      write_reg(vtla_pkg::REG_SHIFT_Y, pick_word());
      write_reg(vtla_pkg::REG_PRIM_MODE, 32'(vtla_pkg::prim_mode_t'(phase % 4)));
      phase_end = vertices_sent + PHASE_ITEMS;
      while (vertices_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0)
          send_vertex(pick_word(), pick_word(), $urandom_range(0, 1) == 1,
                      $urandom_range(0, 9) == 0);
        else
          send_random_shape();
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    vtx_ch.valid <= 1'b0;
    vtx_ch.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_saturation();
    test_prim_modes();
    test_long_contour();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (PIPE_LATENCY * 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("vertex_transform_line_assembler verification clean");
    end else begin
      $display("vertex_transform_line_assembler verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/core/vtla_pkg.sv
rtl/core/vtla_channels.sv
rtl/core/vertex_transform_line_assembler.sv
test/vertex_transform_line_assembler_tb.sv
